FILE: sv/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants for the color blob bounding box unit.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int PIXEL_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int THR_W      = 8;
  localparam int COLOR_W    = 2;
  localparam int SIZE_W     = 13;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [THR_W-1:0]   TARGET_THR_RST = 8'd128;
  localparam logic [THR_W-1:0]   OTHER_THR_RST  = 8'd64;
  localparam logic [SIZE_W-1:0]  WIDTH_RST      = 13'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST     = 13'd480;

  localparam logic [COORD_W-1:0] COORD_NONE     = 16'hFFFF;
  localparam logic [COORD_W-1:0] COORD_ZERO     = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_THR = 3'd0,
    CFG_OTHER_THR  = 3'd1,
    CFG_COLOR      = 3'd2,
    CFG_WIDTH      = 3'd3,
    CFG_HEIGHT     = 3'd4
  } cfg_index_t;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_DEFAULT = 2'd0,
    COLOR_RED     = 2'd1,
    COLOR_GREEN   = 2'd2,
    COLOR_BLUE    = 2'd3
  } color_t;

  // Classified pixel held in the input register.
  typedef struct packed {
    logic hit;
    logic restart;
  } pix_info_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] right_col;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] bottom_row;
  } result_t;

endpackage

FILE: sv/cbb_pixel_if.sv
// ----------------------------------------------------------------------------
// cbb_pixel_if
// Valid/ready channel carrying one RGB pixel and its restart flag.
// ----------------------------------------------------------------------------
interface cbb_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [cbb_pkg::PIXEL_W-1:0] pixel;
  logic                        restart;

  modport source (output valid, output pixel, output restart, input ready);
  modport sink   (input valid, input pixel, input restart, output ready);
endinterface

FILE: sv/cbb_result_if.sv
// ----------------------------------------------------------------------------
// cbb_result_if
// Valid/ready channel carrying one bounding box result per frame.
// ----------------------------------------------------------------------------
interface cbb_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [cbb_pkg::COORD_W-1:0] center_x;
  logic [cbb_pkg::COORD_W-1:0] center_y;
  logic [cbb_pkg::COORD_W-1:0] left_col;
  logic [cbb_pkg::COORD_W-1:0] right_col;
  logic [cbb_pkg::COORD_W-1:0] top_row;
  logic [cbb_pkg::COORD_W-1:0] bottom_row;

  modport source (output valid, output found, output center_x, output center_y,
                  output left_col, output right_col, output top_row,
                  output bottom_row, input ready);
  modport sink   (input valid, input found, input center_x, input center_y,
                  input left_col, input right_col, input top_row,
                  input bottom_row, output ready);
endinterface

FILE: sv/cbb_pixel_classify.sv
// ----------------------------------------------------------------------------
// cbb_pixel_classify
// Flags a pixel whose target channel is above its threshold while both
// other channels are below theirs.
// ----------------------------------------------------------------------------
module cbb_pixel_classify (
  input  logic [cbb_pkg::PIXEL_W-1:0] pixel,
  input  logic [cbb_pkg::THR_W-1:0]   tgt_limit,
  input  logic [cbb_pkg::THR_W-1:0]   oth_limit,
  input  logic [cbb_pkg::COLOR_W-1:0] chan_sel,
  output logic                        hit
);

  logic [cbb_pkg::CHAN_W-1:0] red;
  logic [cbb_pkg::CHAN_W-1:0] green;
  logic [cbb_pkg::CHAN_W-1:0] blue;
  logic [cbb_pkg::CHAN_W-1:0] tgt;
  logic [cbb_pkg::CHAN_W-1:0] oth_a;
  logic [cbb_pkg::CHAN_W-1:0] oth_b;

  assign red   = pixel[23:16];
  assign green = pixel[15:8];
  assign blue  = pixel[7:0];

  always_comb begin
    unique case (cbb_pkg::color_t'(chan_sel)) inside
      cbb_pkg::COLOR_GREEN: begin
        tgt = green; oth_a = red; oth_b = blue;
      end
      cbb_pkg::COLOR_BLUE: begin
        tgt = blue; oth_a = red; oth_b = green;
      end
      cbb_pkg::COLOR_DEFAULT, cbb_pkg::COLOR_RED: begin
        tgt = red; oth_a = green; oth_b = blue;
      end
      default: begin
        tgt = red; oth_a = green; oth_b = blue;
      end
    endcase
  end

  assign hit = (tgt > tgt_limit) && (oth_a < oth_limit) &&
               (oth_b < oth_limit);

endmodule

FILE: sv/cbb_box_tracker.sv
// ----------------------------------------------------------------------------
// cbb_box_tracker
// Raster position counters, per-frame bounding box and frame-end result.
// ----------------------------------------------------------------------------
module cbb_box_tracker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  cbb_pkg::pix_info_t         info,
  input  logic [cbb_pkg::SIZE_W-1:0] frame_width,
  input  logic [cbb_pkg::SIZE_W-1:0] frame_height,
  output logic                       frame_end,
  output cbb_pkg::result_t           result
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int EXW = 17;

  logic [CW-1:0] column, column_next;
  logic [RW-1:0] row, row_next;
  logic [WW-1:0] box_left, box_left_next;
  logic [CW-1:0] box_right, box_right_next;
  logic [HW-1:0] box_top, box_top_next;
  logic [RW-1:0] box_bottom, box_bottom_next;
  logic          hit_seen, hit_seen_next;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic          frame_start;
  logic          last_col;
  logic          last_row;
  logic [EXW-1:0] sum_x;
  logic [EXW-1:0] sum_y;

  // Zero or oversized frame sizes fall back to the maximum.
  always_comb begin
    if (frame_width == '0 || EXW'(frame_width) > EXW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height == '0 || EXW'(frame_height) > EXW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  assign col_cur     = info.restart ? '0 : column;
  assign row_cur     = info.restart ? '0 : row;
  assign frame_start = (col_cur == '0) && (row_cur == '0);
  assign last_col    = WW'(col_cur) == (w_eff - WW'(1));
  assign last_row    = HW'(row_cur) == (h_eff - HW'(1));
  assign frame_end   = last_col && last_row;

  always_comb begin
    box_left_next   = frame_start ? w_eff : box_left;
    box_top_next    = frame_start ? h_eff : box_top;
    box_right_next  = frame_start ? '0 : box_right;
    box_bottom_next = frame_start ? '0 : box_bottom;
    hit_seen_next   = frame_start ? 1'b0 : hit_seen;
    if (info.hit) begin
      if (col_cur > box_right_next)          box_right_next  = col_cur;
      if (WW'(col_cur) < box_left_next)      box_left_next   = WW'(col_cur);
      if (row_cur > box_bottom_next)         box_bottom_next = row_cur;
      if (HW'(row_cur) < box_top_next)       box_top_next    = HW'(row_cur);
      hit_seen_next = 1'b1;
    end
  end

  // Advance the raster position, wrapping at the maximum if a size change
  // left the counter beyond the frame.
  always_comb begin
    column_next = col_cur;
    row_next    = row_cur;
    if (last_col) begin
      column_next = '0;
      if (last_row || row_cur == RW'(MAX_HEIGHT - 1)) begin
        row_next = '0;
      end else begin
        row_next = row_cur + RW'(1);
      end
    end else if (col_cur == CW'(MAX_WIDTH - 1)) begin
      column_next = '0;
    end else begin
      column_next = col_cur + CW'(1);
    end
  end

  assign sum_x = EXW'(box_left_next) + EXW'(box_right_next);
  assign sum_y = EXW'(box_top_next) + EXW'(box_bottom_next);

  always_comb begin
    if (hit_seen_next) begin
      result.found      = 1'b1;
      result.center_x   = sum_x[EXW-1:1];
      result.center_y   = sum_y[EXW-1:1];
      result.left_col   = cbb_pkg::COORD_W'(box_left_next);
      result.right_col  = cbb_pkg::COORD_W'(box_right_next);
      result.top_row    = cbb_pkg::COORD_W'(box_top_next);
      result.bottom_row = cbb_pkg::COORD_W'(box_bottom_next);
    end else begin
      result.found      = 1'b0;
      result.center_x   = cbb_pkg::COORD_NONE;
      result.center_y   = cbb_pkg::COORD_NONE;
      result.left_col   = cbb_pkg::COORD_ZERO;
      result.right_col  = cbb_pkg::COORD_ZERO;
      result.top_row    = cbb_pkg::COORD_NONE;
      result.bottom_row = cbb_pkg::COORD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row        <= '0;
      box_left   <= '0;
      box_right  <= '0;
      box_top    <= '0;
      box_bottom <= '0;
      hit_seen   <= 1'b0;
    end else if (step) begin
      column     <= column_next;
      row        <= row_next;
      box_left   <= box_left_next;
      box_right  <= box_right_next;
      box_top    <= box_top_next;
      box_bottom <= box_bottom_next;
      hit_seen   <= hit_seen_next;
    end
  end

endmodule

FILE: sv/color_blob_bounding_box_unit.sv
// ----------------------------------------------------------------------------
// color_blob_bounding_box_unit
// Color threshold blob tracker: bounding box and center once per frame.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per transfer on pix. Each pixel is
// classified against the configured color thresholds on its way into an
// input register; from there a step updates the column/row counters and the
// bounding box and, on the last pixel of a frame, loads the result register
// that drives res. The unit sustains one pixel per clock: a pixel is taken
// in every cycle unless the input register holds a frame-end pixel while the
// result register still holds an untaken result. The result register loads
// when the frame-end pixel leaves the input register, and the result stays
// on res until it is taken.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
// next edge and are to be made only while no pixel is in flight and no
// result is waiting. A restart flag on a pixel zeroes the position before
// that pixel is handled, so it opens a new frame.
module color_blob_bounding_box_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  cbb_pixel_if.sink                      pix,
  cbb_result_if.source                   res
);

  // Configuration registers.
  logic [cbb_pkg::THR_W-1:0]   tgt_limit;
  logic [cbb_pkg::THR_W-1:0]   oth_limit;
  logic [cbb_pkg::COLOR_W-1:0] chan_sel;
  logic [cbb_pkg::SIZE_W-1:0]  frame_width;
  logic [cbb_pkg::SIZE_W-1:0]  frame_height;

  // Input register and result register.
  logic               s1_valid;
  cbb_pkg::pix_info_t s1_info;
  logic               pix_hit;
  logic               s1_step;
  logic               out_free;
  logic               frame_end;
  cbb_pkg::result_t   trk_result;
  logic               out_valid;
  cbb_pkg::result_t   out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_limit    <= cbb_pkg::TARGET_THR_RST;
      oth_limit    <= cbb_pkg::OTHER_THR_RST;
      chan_sel     <= cbb_pkg::COLOR_RED;
      frame_width  <= cbb_pkg::WIDTH_RST;
      frame_height <= cbb_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cbb_pkg::cfg_index_t'(cfg_index))
        cbb_pkg::CFG_TARGET_THR: tgt_limit    <= cfg_wdata[cbb_pkg::THR_W-1:0];
        cbb_pkg::CFG_OTHER_THR:  oth_limit    <= cfg_wdata[cbb_pkg::THR_W-1:0];
        cbb_pkg::CFG_COLOR:      chan_sel     <= cfg_wdata[cbb_pkg::COLOR_W-1:0];
        cbb_pkg::CFG_WIDTH:      frame_width  <= cfg_wdata[cbb_pkg::SIZE_W-1:0];
        cbb_pkg::CFG_HEIGHT:     frame_height <= cfg_wdata[cbb_pkg::SIZE_W-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Classify on the way in so the input register holds a single hit bit.
  cbb_pixel_classify u_classify (
    .pixel     (pix.pixel),
    .tgt_limit (tgt_limit),
    .oth_limit (oth_limit),
    .chan_sel  (chan_sel),
    .hit       (pix_hit)
  );

  // The result slot is free when empty or being taken this cycle.
  assign out_free = !out_valid || res.ready;

  // A pixel that closes a frame needs the result slot; others never wait.
  assign s1_step   = s1_valid && (!frame_end || out_free);
  assign pix.ready = !s1_valid || s1_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix.ready) begin
      s1_valid <= pix.valid;
    end
  end

  // Payload only changes on a transfer; hold it otherwise.
  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      s1_info.hit     <= pix_hit;
      s1_info.restart <= pix.restart;
    end
  end

  cbb_box_tracker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_step),
    .info         (s1_info),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .frame_end    (frame_end),
    .result       (trk_result)
  );

  // Result register: load on a frame-end step, drop once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_step && frame_end) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && frame_end) begin
      out_data <= trk_result;
    end
  end

  assign res.valid      = out_valid;
  assign res.found      = out_data.found;
  assign res.center_x   = out_data.center_x;
  assign res.center_y   = out_data.center_y;
  assign res.left_col   = out_data.left_col;
  assign res.right_col  = out_data.right_col;
  assign res.top_row    = out_data.top_row;
  assign res.bottom_row = out_data.bottom_row;

  // A frame-end step never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_step && frame_end |-> out_free)
    else $error("frame result loaded while previous result still pending");

  // A transferred pixel always lands in the input register.
  a_pixel_lands: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |=> s1_valid)
    else $error("accepted pixel lost from input register");

  // A found box is never inverted.
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.found |->
      res.left_col <= res.right_col && res.top_row <= res.bottom_row)
    else $error("bounding box edges out of order");

endmodule
